>>> hdl/latching_relay_pulse_driver_unit_defines.svh
// Assertion macros shared by the checker of the latching relay pulse driver.
// Depends on signals clk and rst_n being visible where a macro is used.
`ifndef LATCHING_RELAY_PULSE_DRIVER_UNIT_DEFINES_SVH
`define LATCHING_RELAY_PULSE_DRIVER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define LRPD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("relay driver check failed");

// Next-cycle implication, disabled while reset is asserted
`define LRPD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("relay driver check failed");

`endif

>>> hdl/lrpd_pkg.sv
// Types and constants of the latching relay pulse driver.
// No dependencies; used by the interfaces and all modules.
`default_nettype none

package lrpd_pkg;

    localparam int PULSE_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [PULSE_W-1:0] PULSE_RESET = 16'd100;
    localparam logic [PULSE_W-1:0] ELAPSED_MAX = 16'hFFFF;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ON_PULSE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_PULSE = 2'd1;

    // Request kinds
    typedef enum logic [1:0] {
        KIND_STEP   = 2'd0,
        KIND_SET    = 2'd1,
        KIND_TOGGLE = 2'd2,
        KIND_TICK   = 2'd3
    } kind_t;

    // Relay condition as reported on relay_status
    typedef enum logic [1:0] {
        COND_UNKNOWN = 2'd0,
        COND_TRANS   = 2'd1,
        COND_ON      = 2'd2,
        COND_OFF     = 2'd3
    } cond_t;

    // Switching sequence, one-hot
    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_INIT_ON   = 7'b0000010,
        ST_DRIVE_ON  = 7'b0000100,
        ST_DONE_ON   = 7'b0001000,
        ST_INIT_OFF  = 7'b0010000,
        ST_DRIVE_OFF = 7'b0100000,
        ST_DONE_OFF  = 7'b1000000
    } step_t;

    // One result item
    typedef struct packed {
        logic  on_coil;
        logic  off_coil;
        cond_t relay_status;
    } result_t;

endpackage

`default_nettype wire

>>> hdl/lrpd_channels.sv
// Valid/ready channel interfaces for requests and results.
// Depends on lrpd_pkg.
`default_nettype none

interface lrpd_req_if;
    logic                valid;
    logic                ready;
    lrpd_pkg::kind_t     kind;
    logic                level;

    modport source (output valid, output kind, output level, input ready);
    modport sink   (input valid, input kind, input level, output ready);
endinterface

interface lrpd_rsp_if;
    logic                valid;
    logic                ready;
    logic                on_coil;
    logic                off_coil;
    lrpd_pkg::cond_t     relay_status;

    modport source (output valid, output on_coil, output off_coil, output relay_status,
                    input ready);
    modport sink   (input valid, input on_coil, input off_coil, input relay_status,
                    output ready);
endinterface

`default_nettype wire

>>> hdl/latching_relay_pulse_driver_unit.sv
// Latching relay pulse driver, top level: configuration registers and result stage.
// Depends on lrpd_pkg, lrpd_channels and lrpd_seq.
//
// Takes one request per clock (step, set, toggle, millisecond tick) unless stalled
// and returns exactly one result for each, in the cycle after the request is
// accepted. The rate of one item per cycle is set by the state update in the
// sequencer and the one-entry result register; the request side stays ready while
// that register is empty or being drained in the same cycle. There is no clearing
// pass after reset. Users must write pulse lengths (cfg_we/cfg_index/cfg_data) only
// while idle, unchecked; indexes other than the two pulse registers are ignored.
`default_nettype none

module latching_relay_pulse_driver_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [lrpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lrpd_pkg::PULSE_W-1:0]    cfg_data,
    lrpd_req_if.sink                             request,
    lrpd_rsp_if.source                           result
);

    logic [lrpd_pkg::PULSE_W-1:0] on_pulse_reg;
    logic [lrpd_pkg::PULSE_W-1:0] off_pulse_reg;
    logic                         rsp_valid_reg;
    lrpd_pkg::result_t            rsp_data_reg;
    lrpd_pkg::result_t            seq_result;
    logic                         req_accept;

    // Pulse length registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_pulse_reg  <= lrpd_pkg::PULSE_RESET;
            off_pulse_reg <= lrpd_pkg::PULSE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lrpd_pkg::CFG_ON_PULSE:  on_pulse_reg  <= cfg_data;
                lrpd_pkg::CFG_OFF_PULSE: off_pulse_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Request handshake
    assign request.ready = !rsp_valid_reg || result.ready;
    assign req_accept    = request.valid && request.ready;

    lrpd_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (req_accept),
        .kind      (request.kind),
        .level     (request.level),
        .on_pulse  (on_pulse_reg),
        .off_pulse (off_pulse_reg),
        .result    (seq_result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (req_accept)
            rsp_valid_reg <= 1'b1;
        else if (result.ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
            rsp_data_reg <= seq_result;
    end

    assign result.valid        = rsp_valid_reg;
    assign result.on_coil      = rsp_data_reg.on_coil;
    assign result.off_coil     = rsp_data_reg.off_coil;
    assign result.relay_status = rsp_data_reg.relay_status;

endmodule

`default_nettype wire

>>> hdl/lrpd_seq.sv
// Switching sequencer: relay state, millisecond counter and coil drives.
// Depends on lrpd_pkg. Updates once per accepted request.
`default_nettype none

module lrpd_seq (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          advance,
    input  wire lrpd_pkg::kind_t               kind,
    input  wire logic                          level,
    input  wire logic [lrpd_pkg::PULSE_W-1:0]  on_pulse,
    input  wire logic [lrpd_pkg::PULSE_W-1:0]  off_pulse,
    output lrpd_pkg::result_t                  result
);

    lrpd_pkg::step_t              step_reg, step_next;
    lrpd_pkg::cond_t              cond_reg, cond_next;
    logic [lrpd_pkg::PULSE_W-1:0] elapsed_reg, elapsed_next;
    logic                         on_drive_reg, on_drive_next;
    logic                         off_drive_reg, off_drive_next;

    // Next state for one request
    always_comb
    begin
        step_next      = step_reg;
        cond_next      = cond_reg;
        elapsed_next   = elapsed_reg;
        on_drive_next  = on_drive_reg;
        off_drive_next = off_drive_reg;
        case (kind)
            lrpd_pkg::KIND_STEP:
            begin
                unique case (step_reg)
                    lrpd_pkg::ST_INIT_ON:
                    begin
                        cond_next    = lrpd_pkg::COND_TRANS;
                        step_next    = lrpd_pkg::ST_DRIVE_ON;
                        elapsed_next = '0;
                    end
                    lrpd_pkg::ST_DRIVE_ON:
                    begin
                        on_drive_next = 1'b1;
                        if (elapsed_reg >= on_pulse)
                            step_next = lrpd_pkg::ST_DONE_ON;
                    end
                    lrpd_pkg::ST_DONE_ON:
                    begin
                        cond_next      = lrpd_pkg::COND_ON;
                        step_next      = lrpd_pkg::ST_IDLE;
                        on_drive_next  = 1'b0;
                        off_drive_next = 1'b0;
                    end
                    lrpd_pkg::ST_INIT_OFF:
                    begin
                        cond_next    = lrpd_pkg::COND_TRANS;
                        step_next    = lrpd_pkg::ST_DRIVE_OFF;
                        elapsed_next = '0;
                    end
                    lrpd_pkg::ST_DRIVE_OFF:
                    begin
                        off_drive_next = 1'b1;
                        if (elapsed_reg >= off_pulse)
                            step_next = lrpd_pkg::ST_DONE_OFF;
                    end
                    lrpd_pkg::ST_DONE_OFF:
                    begin
                        cond_next      = lrpd_pkg::COND_OFF;
                        step_next      = lrpd_pkg::ST_IDLE;
                        on_drive_next  = 1'b0;
                        off_drive_next = 1'b0;
                    end
                    default:
                    begin
                        step_next = step_reg;
                    end
                endcase
            end
            lrpd_pkg::KIND_SET:
            begin
                step_next = level ? lrpd_pkg::ST_INIT_ON : lrpd_pkg::ST_INIT_OFF;
            end
            lrpd_pkg::KIND_TOGGLE:
            begin
                // ignored while transitioning; unknown counts as off
                if (cond_reg == lrpd_pkg::COND_ON)
                    step_next = lrpd_pkg::ST_INIT_OFF;
                else if (cond_reg != lrpd_pkg::COND_TRANS)
                    step_next = lrpd_pkg::ST_INIT_ON;
            end
            default:
            begin
                // tick: saturating count
                if (elapsed_reg != lrpd_pkg::ELAPSED_MAX)
                    elapsed_next = elapsed_reg + 1'b1;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= lrpd_pkg::ST_IDLE;
            cond_reg      <= lrpd_pkg::COND_UNKNOWN;
            elapsed_reg   <= '0;
            on_drive_reg  <= 1'b0;
            off_drive_reg <= 1'b0;
        end
        else if (advance)
        begin
            step_reg      <= step_next;
            cond_reg      <= cond_next;
            elapsed_reg   <= elapsed_next;
            on_drive_reg  <= on_drive_next;
            off_drive_reg <= off_drive_next;
        end
    end

    // Result reflects the state after this request
    assign result.on_coil      = on_drive_next;
    assign result.off_coil     = off_drive_next;
    assign result.relay_status = cond_next;

endmodule

`default_nettype wire

>>> hdl/lrpd_checker.sv
// Port-level checks for the latching relay pulse driver, bound to its top level.
// Depends on lrpd_pkg and latching_relay_pulse_driver_unit_defines.svh.
`default_nettype none

`include "latching_relay_pulse_driver_unit_defines.svh"

module lrpd_checker (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             in_ready,
    input  wire logic             out_valid,
    input  wire logic             out_ready,
    input  wire logic             on_coil,
    input  wire logic             off_coil,
    input  wire lrpd_pkg::cond_t  relay_status
);

    // A stalled result keeps its payload
    `LRPD_ASSERT_NEXT(a_rsp_hold, out_valid && !out_ready, out_valid && $stable({on_coil, off_coil, relay_status}))

    // Every accepted request shows a result on the next cycle
    `LRPD_ASSERT_NEXT(a_rsp_follows, in_valid && in_ready, out_valid)

    // With the result stage empty the block takes requests
    `LRPD_ASSERT_NOW(a_ready_empty, !out_valid, in_ready)

    // A coil is driven only while the relay is transitioning
    `LRPD_ASSERT_NOW(a_drive_trans, out_valid && (on_coil || off_coil), relay_status == lrpd_pkg::COND_TRANS)

endmodule

bind latching_relay_pulse_driver_unit lrpd_checker u_lrpd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (request.valid),
    .in_ready     (request.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .on_coil      (result.on_coil),
    .off_coil     (result.off_coil),
    .relay_status (result.relay_status)
);

`default_nettype wire

>>> tb/relay_result_checker.sv
// Result checker for the latching relay pulse driver: predicts coil drive and relay status.
// Depends on lrpd_pkg and the lrpd_req_if / lrpd_rsp_if channel interfaces.
`default_nettype none

module relay_result_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [lrpd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lrpd_pkg::PULSE_W-1:0]     cfg_data,
    lrpd_req_if                                   request,
    lrpd_rsp_if                                   result,
    output int                                    mismatches,
    output int                                    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow of the pulse registers and of the switching sequence
    logic [lrpd_pkg::PULSE_W-1:0] on_pulse_len;
    logic [lrpd_pkg::PULSE_W-1:0] off_pulse_len;
    lrpd_pkg::step_t              seq_step;
    lrpd_pkg::cond_t              relay_cond;
    logic [lrpd_pkg::PULSE_W-1:0] ms_count;
    logic                         on_drv;
    logic                         off_drv;

    // Coil and status values expected for accepted requests, oldest first
    lrpd_pkg::result_t            coil_expect_q[$];

    // One handler step of the switching sequence
    task automatic walk_sequence();
        case (seq_step)
            lrpd_pkg::ST_INIT_ON:
            begin
                relay_cond = lrpd_pkg::COND_TRANS;
                seq_step   = lrpd_pkg::ST_DRIVE_ON;
                ms_count   = '0;
            end
            lrpd_pkg::ST_DRIVE_ON:
            begin
                on_drv = 1'b1;
                if (ms_count >= on_pulse_len)
                    seq_step = lrpd_pkg::ST_DONE_ON;
            end
            lrpd_pkg::ST_DONE_ON:
            begin
                relay_cond = lrpd_pkg::COND_ON;
                seq_step   = lrpd_pkg::ST_IDLE;
                on_drv     = 1'b0;
                off_drv    = 1'b0;
            end
            lrpd_pkg::ST_INIT_OFF:
            begin
                relay_cond = lrpd_pkg::COND_TRANS;
                seq_step   = lrpd_pkg::ST_DRIVE_OFF;
                ms_count   = '0;
            end
            lrpd_pkg::ST_DRIVE_OFF:
            begin
                off_drv = 1'b1;
                if (ms_count >= off_pulse_len)
                    seq_step = lrpd_pkg::ST_DONE_OFF;
            end
            lrpd_pkg::ST_DONE_OFF:
            begin
                relay_cond = lrpd_pkg::COND_OFF;
                seq_step   = lrpd_pkg::ST_IDLE;
                on_drv     = 1'b0;
                off_drv    = 1'b0;
            end
            default:
            begin
            end
        endcase
    endtask

    // Apply one request and return the coil/status it leaves behind
    task automatic apply_relay_request(input lrpd_pkg::kind_t kind, input logic level,
                                       output lrpd_pkg::result_t outcome);
        case (kind)
            lrpd_pkg::KIND_STEP:
                walk_sequence();
            lrpd_pkg::KIND_SET:
                seq_step = level ? lrpd_pkg::ST_INIT_ON : lrpd_pkg::ST_INIT_OFF;
            lrpd_pkg::KIND_TOGGLE:
            begin
                // ignored while transitioning; unknown counts as off
                if (relay_cond == lrpd_pkg::COND_ON)
                    seq_step = lrpd_pkg::ST_INIT_OFF;
                else if (relay_cond != lrpd_pkg::COND_TRANS)
                    seq_step = lrpd_pkg::ST_INIT_ON;
            end
            default:
            begin
                // millisecond tick, saturating
                if (ms_count != lrpd_pkg::ELAPSED_MAX)
                    ms_count = ms_count + 1'b1;
            end
        endcase
        outcome.on_coil      = on_drv;
        outcome.off_coil     = off_drv;
        outcome.relay_status = relay_cond;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        lrpd_pkg::result_t want;
        lrpd_pkg::result_t got;
        if (!rst_n)
        begin
            on_pulse_len  = lrpd_pkg::PULSE_RESET;
            off_pulse_len = lrpd_pkg::PULSE_RESET;
            seq_step      = lrpd_pkg::ST_IDLE;
            relay_cond    = lrpd_pkg::COND_UNKNOWN;
            ms_count      = '0;
            on_drv        = 1'b0;
            off_drv       = 1'b0;
            coil_expect_q.delete();
            mismatches    = 0;
            outstanding   = 0;
        end
        else
        begin
            // register writes; unknown indexes fall through
            if (cfg_we)
            begin
                case (cfg_index)
                    lrpd_pkg::CFG_ON_PULSE:  on_pulse_len  = cfg_data;
                    lrpd_pkg::CFG_OFF_PULSE: off_pulse_len = cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            // results first: one accepted this edge belongs to an earlier request
            if (result.valid && result.ready)
            begin
                got.on_coil      = result.on_coil;
                got.off_coil     = result.off_coil;
                got.relay_status = result.relay_status;
                if (coil_expect_q.size() == 0)
                begin
                    $error("result with no request outstanding: %s %0d %s %0d %s %0d",
                           "on_coil", got.on_coil, "off_coil", got.off_coil,
                           "relay_status", got.relay_status);
                    mismatches++;
                end
                else
                begin
                    want = coil_expect_q.pop_front();
                    if (got.on_coil !== want.on_coil)
                    begin
                        $error("on_coil: expected %0d, actual %0d", want.on_coil, got.on_coil);
                        mismatches++;
                    end
                    if (got.off_coil !== want.off_coil)
                    begin
                        $error("off_coil: expected %0d, actual %0d", want.off_coil, got.off_coil);
                        mismatches++;
                    end
                    if (got.relay_status !== want.relay_status)
                    begin
                        $error("relay_status: expected %0d, actual %0d",
                               want.relay_status, got.relay_status);
                        mismatches++;
                    end
                end
            end

            if (request.valid && request.ready)
            begin
                apply_relay_request(request.kind, request.level, want);
                coil_expect_q.push_back(want);
            end

            outstanding = coil_expect_q.size();
        end
    end

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Top of the relay driver testbench: clock, reset, request/register stimulus and verdict.
// Depends on lrpd_pkg, lrpd_channels, the driver top level and relay_result_checker.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Register indexes past the two pulse registers; writes to them are dropped
    localparam logic [lrpd_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [lrpd_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
    localparam int QUIET_LIMIT = 5000;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             cfg_we;
    logic [lrpd_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [lrpd_pkg::PULSE_W-1:0]     cfg_data;
    logic                             idle_on;
    int                               mismatches;
    int                               outstanding;
    int                               quiet_cycles;

    lrpd_req_if req_ch();
    lrpd_rsp_if rsp_ch();

    latching_relay_pulse_driver_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .request   (req_ch),
        .result    (rsp_ch)
    );

    relay_result_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .request     (req_ch),
        .result      (rsp_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #6 clk = ~clk;

    // Result side: stall about a quarter of the cycles while idling is enabled
    always @(posedge clk)
        rsp_ch.ready <= !idle_on || ($urandom_range(99) >= 25);

    // Watchdog on cycles in which neither channel moves anything
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Register write, only while the driver is idle
    task automatic write_reg(input logic [lrpd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lrpd_pkg::PULSE_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one request, with random gaps in front; returns at its accepting edge
    task automatic send_req(input lrpd_pkg::kind_t kind, input logic level);
        while (idle_on && ($urandom_range(99) < 25))
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.kind  <= kind;
        req_ch.level <= level;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic hold_until_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic settle();
        hold_until_drained();
        repeat (3) @(posedge clk);
    endtask

    // Mostly commands followed by runs of steps and ticks, the rest single random requests
    task automatic run_mix(input int unsigned quota);
        int unsigned sent;
        int unsigned run_len;
        sent = 0;
        while (sent < quota)
        begin
            if ($urandom_range(99) < 75)
            begin
                if ($urandom_range(1) == 1)
                    send_req(lrpd_pkg::KIND_SET, 1'($urandom_range(1)));
                else
                    send_req(lrpd_pkg::KIND_TOGGLE, 1'($urandom_range(1)));
                run_len = $urandom_range(12, 2);
                repeat (run_len)
                    send_req(($urandom_range(1) == 1) ? lrpd_pkg::KIND_STEP
                                                      : lrpd_pkg::KIND_TICK,
                             1'($urandom_range(1)));
                sent += run_len + 1;
            end
            else
            begin
                send_req(lrpd_pkg::kind_t'($urandom_range(3)), 1'($urandom_range(1)));
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = lrpd_pkg::CFG_ON_PULSE;
        cfg_data     = '0;
        idle_on      = 1'b1;
        req_ch.valid = 1'b0;
        req_ch.kind  = lrpd_pkg::KIND_STEP;
        req_ch.level = 1'b0;
        rsp_ch.ready = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // spare indexes must leave the pulse lengths alone
        write_reg(CFG_SPARE_2, 16'hFFFF);
        write_reg(CFG_SPARE_3, 16'h0000);
        write_reg(lrpd_pkg::CFG_ON_PULSE, 16'd0);
        write_reg(lrpd_pkg::CFG_OFF_PULSE, 16'd0);

        // Directed: zero pulses, toggles from every condition, set during a sequence
        send_req(lrpd_pkg::KIND_STEP, 1'b1);      // step while idle
        send_req(lrpd_pkg::KIND_TICK, 1'b1);
        send_req(lrpd_pkg::KIND_TOGGLE, 1'b0);    // unknown -> on
        send_req(lrpd_pkg::KIND_STEP, 1'b0);
        send_req(lrpd_pkg::KIND_TOGGLE, 1'b1);    // ignored while transitioning
        send_req(lrpd_pkg::KIND_STEP, 1'b0);      // zero pulse finishes on first drive step
        send_req(lrpd_pkg::KIND_STEP, 1'b0);
        send_req(lrpd_pkg::KIND_TOGGLE, 1'b0);    // on -> off
        repeat (3) send_req(lrpd_pkg::KIND_STEP, 1'b0);
        send_req(lrpd_pkg::KIND_TOGGLE, 1'b1);    // off -> on
        send_req(lrpd_pkg::KIND_STEP, 1'b0);
        send_req(lrpd_pkg::KIND_STEP, 1'b0);      // on coil driven
        send_req(lrpd_pkg::KIND_SET, 1'b0);       // restart toward off with on coil still driven
        send_req(lrpd_pkg::KIND_STEP, 1'b0);
        send_req(lrpd_pkg::KIND_STEP, 1'b0);      // both coils driven
        send_req(lrpd_pkg::KIND_STEP, 1'b0);
        send_req(lrpd_pkg::KIND_SET, 1'b1);
        send_req(lrpd_pkg::KIND_SET, 1'b0);       // set on a pending start
        send_req(lrpd_pkg::KIND_STEP, 1'b1);
        send_req(lrpd_pkg::KIND_TICK, 1'b0);
        repeat (3) send_req(lrpd_pkg::KIND_STEP, 1'b0);
        settle();

        // Longest pulses and a long tick run, no idling on either side
        idle_on = 1'b0;
        write_reg(lrpd_pkg::CFG_ON_PULSE, 16'hFFFF);
        write_reg(lrpd_pkg::CFG_OFF_PULSE, 16'hFFFF);
        send_req(lrpd_pkg::KIND_SET, 1'b1);
        send_req(lrpd_pkg::KIND_STEP, 1'b0);
        send_req(lrpd_pkg::KIND_STEP, 1'b0);
        repeat (100) send_req(lrpd_pkg::KIND_TICK, 1'b1);
        send_req(lrpd_pkg::KIND_STEP, 1'b0);
        send_req(lrpd_pkg::KIND_STEP, 1'b0);
        send_req(lrpd_pkg::KIND_SET, 1'b0);
        send_req(lrpd_pkg::KIND_STEP, 1'b1);
        send_req(lrpd_pkg::KIND_STEP, 1'b0);
        repeat (5) send_req(lrpd_pkg::KIND_TICK, 1'b0);
        send_req(lrpd_pkg::KIND_STEP, 1'b0);
        send_req(lrpd_pkg::KIND_SET, 1'b1);
        send_req(lrpd_pkg::KIND_STEP, 1'b0);
        settle();

        // Random mixes over several pulse settings
        idle_on = 1'b1;
        write_reg(lrpd_pkg::CFG_ON_PULSE, 16'd0);
        write_reg(lrpd_pkg::CFG_OFF_PULSE, 16'hFFFF);
        run_mix(270);
        settle();

        write_reg(lrpd_pkg::CFG_ON_PULSE, 16'd1);
        write_reg(lrpd_pkg::CFG_OFF_PULSE, 16'd2);
        run_mix(135);
        hold_until_drained();
        run_mix(135);
        settle();

        write_reg(lrpd_pkg::CFG_ON_PULSE, 16'($urandom_range(6)));
        write_reg(lrpd_pkg::CFG_OFF_PULSE, 16'($urandom_range(6)));
        run_mix(270);
        settle();

        write_reg(lrpd_pkg::CFG_ON_PULSE, 16'd5);
        write_reg(lrpd_pkg::CFG_OFF_PULSE, 16'd0);
        run_mix(270);
        settle();

        write_reg(lrpd_pkg::CFG_ON_PULSE, 16'($urandom_range(15)));
        write_reg(lrpd_pkg::CFG_OFF_PULSE, 16'($urandom_range(15)));
        run_mix(270);
        settle();

        if (mismatches == 0 && outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
+incdir+hdl
hdl/lrpd_pkg.sv
hdl/lrpd_channels.sv
hdl/lrpd_seq.sv
hdl/latching_relay_pulse_driver_unit.sv
hdl/lrpd_checker.sv
tb/relay_result_checker.sv
tb/testbench.sv
